@@ rtl/jfcd_pkg.sv @@
// Shared constants, codes and control structs for the joint frame change detector.
// No dependencies; every other file in the project imports this package.
package jfcd_pkg;

  localparam int NUM_JOINTS_DEF = 32;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int ID_W       = 5;
  localparam int STATE_W    = 4;
  localparam int ERROR_W    = 8;
  localparam int REASON_W   = 3;
  localparam int AGE_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRESHNESS_LIMIT = 2'd1;

  localparam logic [REASON_W-1:0] REASON_NONE   = 3'd0;
  localparam logic [REASON_W-1:0] REASON_FIRST  = 3'd1;
  localparam logic [REASON_W-1:0] REASON_STATUS = 3'd2;
  localparam logic [REASON_W-1:0] REASON_ANGLE  = 3'd3;
  localparam logic [REASON_W-1:0] REASON_STALE  = 3'd4;

  localparam logic [CFG_DATA_W-1:0] FRESHNESS_RESET = 16'd100;
  localparam logic [AGE_W-1:0]      AGE_MAX         = '1;

  typedef struct packed {
    logic take;
    logic close;
    logic commit;
  } store_ctrl_t;

  typedef struct packed {
    logic pend_hit;
    logic base_hit;
    logic have_base;
  } store_stat_t;

endpackage

@@ rtl/jfcd_in_if.sv @@
// Joint record / tick input channel: valid, ready and one input item.
// Depends on jfcd_pkg for field widths.
interface jfcd_in_if #(parameter int ANGLE_BITS = jfcd_pkg::ANGLE_BITS_DEF);
  import jfcd_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [ID_W-1:0]              joint_id;
  logic [STATE_W-1:0]           joint_state;
  logic [ERROR_W-1:0]           joint_error;
  logic signed [ANGLE_BITS-1:0] angle;
  logic                         last_in_frame;

  modport source (
    output valid, opcode, joint_id, joint_state, joint_error, angle, last_in_frame,
    input  ready
  );

  modport sink (
    input  valid, opcode, joint_id, joint_state, joint_error, angle, last_in_frame,
    output ready
  );

endinterface

@@ rtl/jfcd_out_if.sv @@
// Frame decision output channel: valid, ready, deliver flag and reason code.
// Depends on jfcd_pkg for field widths.
interface jfcd_out_if;
  import jfcd_pkg::*;

  logic                valid;
  logic                ready;
  logic                deliver;
  logic [REASON_W-1:0] reason;

  modport source (output valid, deliver, reason, input ready);
  modport sink (input valid, deliver, reason, output ready);

endinterface

@@ rtl/jfcd_cfg_if.sv @@
// Configuration write channel: valid, ready, register index and write data.
// Depends on jfcd_pkg for field widths.
interface jfcd_cfg_if;
  import jfcd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);

endinterface

@@ rtl/jfcd_joint_store.sv @@
// Per-joint pending and baseline storage, double-banked so a frame commit is a bank flip.
// Depends on jfcd_pkg for the control and status structs.
module jfcd_joint_store #(
  parameter int NUM_JOINTS = jfcd_pkg::NUM_JOINTS_DEF,
  parameter int REC_W      = 12 + jfcd_pkg::ANGLE_BITS_DEF,
  localparam int IDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IDX_W-1:0]      idx,
  input  jfcd_pkg::store_ctrl_t ctrl,
  input  logic [REC_W-1:0]      wr_rec,
  output jfcd_pkg::store_stat_t stat,
  output logic [REC_W-1:0]      base_rec
);
  import jfcd_pkg::*;

  logic [NUM_JOINTS-1:0] pend_valid;
  logic [NUM_JOINTS-1:0] base_valid;
  logic [NUM_JOINTS-1:0] base_sel;
  logic [NUM_JOINTS-1:0] pend_set;
  logic [NUM_JOINTS-1:0] pend_all;
  logic [REC_W-1:0]      bank_a [NUM_JOINTS];
  logic [REC_W-1:0]      bank_b [NUM_JOINTS];

  always_comb begin
    pend_set = '0;
    if (ctrl.take) begin
      pend_set[idx] = 1'b1;
    end
    pend_all = pend_valid | pend_set;
  end

  assign stat.pend_hit  = pend_valid[idx];
  assign stat.base_hit  = base_valid[idx];
  assign stat.have_base = |base_valid;
  assign base_rec       = base_sel[idx] ? bank_b[idx] : bank_a[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= '0;
      base_valid <= '0;
      base_sel   <= '0;
    end else begin
      if (ctrl.close) begin
        pend_valid <= '0;
      end else begin
        pend_valid <= pend_all;
      end
      if (ctrl.commit) begin
        base_valid <= pend_all;
        base_sel   <= base_sel ^ pend_all;
      end
    end
  end

  // write the bank that does not hold the baseline for this joint
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      if (base_sel[idx]) begin
        bank_a[idx] <= wr_rec;
      end else begin
        bank_b[idx] <= wr_rec;
      end
    end
  end

endmodule

@@ rtl/joint_frame_change_detector_core.sv @@
// Joint frame change detector: deadband report-by-exception over frames of joint records.
// Depends on jfcd_pkg, the jfcd_*_if interfaces and jfcd_joint_store.
//
// Usage:
//   rec  - input transactions: opcode 0 is a one millisecond tick, opcode 1 a joint
//          record; last_in_frame on a record closes the frame.
//   res  - one result transaction per closed frame (deliver, reason); ticks and
//          records that do not close a frame give none.
//   cfg  - register writes, always ready: index 0 angle_threshold, 1 freshness_limit_ms;
//          other indexes are ignored. Write only while the block is idle.
// Timing:
//   An accepted transaction is registered, then evaluated from that register against the
//   per-joint store (one indexed read, angle subtract and compare), and a result lands
//   in the output register: res.valid rises once the closing record has passed from the
//   input register to the output register. Throughput is one transaction per cycle,
//   set by the single store access per item, while no held result stalls a closing record.
// Reset (rst, synchronous): clears the baseline, pending frame, hit flags, age counter,
//   both channel valids, and loads register defaults (threshold 0, freshness 100 ms).
// Stall: a result held in the output register while res.ready is low holds the next
//   frame-closing record in the input register and rec.ready drops behind it; ticks and
//   records ahead of that record keep flowing.
module joint_frame_change_detector_core #(
  parameter int NUM_JOINTS = jfcd_pkg::NUM_JOINTS_DEF,
  parameter int ANGLE_BITS = jfcd_pkg::ANGLE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  jfcd_in_if.sink  rec,
  jfcd_out_if.source res,
  jfcd_cfg_if.sink cfg
);
  import jfcd_pkg::*;

  localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int REC_W = STATE_W + ERROR_W + ANGLE_BITS;
  localparam int DW    = ANGLE_BITS + 1;

  logic                  q_valid;
  logic                  q_op;
  logic [ID_W-1:0]       q_id;
  logic [STATE_W-1:0]    q_state;
  logic [ERROR_W-1:0]    q_error;
  logic [ANGLE_BITS-1:0] q_angle;
  logic                  q_last;

  logic [CFG_DATA_W-1:0] angle_threshold;
  logic [CFG_DATA_W-1:0] freshness_limit;
  logic                  status_hit;
  logic                  angle_hit;
  logic [AGE_W-1:0]      age;

  logic                  out_valid;
  logic                  out_deliver;
  logic [REASON_W-1:0]   out_reason;

  logic                  is_rec;
  logic                  closes;
  logic                  out_free;
  logic                  go;
  logic                  in_range;
  logic [IDX_W-1:0]      idx;
  logic                  take;
  store_ctrl_t           ctrl;
  store_stat_t           stat;
  logic [REC_W-1:0]      base_rec;
  logic [STATE_W-1:0]    base_state;
  logic [ERROR_W-1:0]    base_error;
  logic [ANGLE_BITS-1:0] base_angle;
  logic signed [DW-1:0]  diff;
  logic [DW-1:0]         diff_abs;
  logic                  rec_status;
  logic                  rec_angle;
  logic                  status_now;
  logic                  angle_now;
  logic [REASON_W-1:0]   reason_next;

  jfcd_joint_store #(
    .NUM_JOINTS (NUM_JOINTS),
    .REC_W      (REC_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .idx      (idx),
    .ctrl     (ctrl),
    .wr_rec   ({q_state, q_error, q_angle}),
    .stat     (stat),
    .base_rec (base_rec)
  );

  assign {base_state, base_error, base_angle} = base_rec;

  always_comb begin
    is_rec   = (q_op == OP_RECORD);
    closes   = is_rec && q_last;
    out_free = !out_valid || res.ready;
    go       = q_valid && (!closes || out_free);
    in_range = 32'(q_id) < NUM_JOINTS;
    idx      = IDX_W'(q_id);
    take     = go && is_rec && in_range && !stat.pend_hit;

    diff     = $signed({q_angle[ANGLE_BITS-1], q_angle})
             - $signed({base_angle[ANGLE_BITS-1], base_angle});
    diff_abs = diff[DW-1] ? DW'(-diff) : DW'(diff);

    rec_status = take && (!stat.base_hit || (base_state != q_state)
                          || (base_error != q_error));
    rec_angle  = take && stat.base_hit
                 && ({{CFG_DATA_W{1'b0}}, diff_abs} > {{DW{1'b0}}, angle_threshold});
    status_now = status_hit || rec_status;
    angle_now  = angle_hit || rec_angle;

    if (!stat.have_base) begin
      reason_next = REASON_FIRST;
    end else if (status_now) begin
      reason_next = REASON_STATUS;
    end else if (angle_now) begin
      reason_next = REASON_ANGLE;
    end else if (age > freshness_limit) begin
      reason_next = REASON_STALE;
    end else begin
      reason_next = REASON_NONE;
    end

    ctrl.take   = take;
    ctrl.close  = go && closes;
    ctrl.commit = go && closes && (reason_next != REASON_NONE);
  end

  assign rec.ready   = !q_valid || go;
  assign res.valid   = out_valid;
  assign res.deliver = out_deliver;
  assign res.reason  = out_reason;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid         <= 1'b0;
      out_valid       <= 1'b0;
      angle_threshold <= '0;
      freshness_limit <= FRESHNESS_RESET;
      status_hit      <= 1'b0;
      angle_hit       <= 1'b0;
      age             <= '0;
    end else begin
      if (rec.valid && rec.ready) begin
        q_valid <= 1'b1;
      end else if (go) begin
        q_valid <= 1'b0;
      end

      if (go && !is_rec && (age != AGE_MAX)) begin
        age <= age + 1'b1;
      end else if (ctrl.commit) begin
        age <= '0;
      end

      if (ctrl.close) begin
        status_hit <= 1'b0;
        angle_hit  <= 1'b0;
      end else if (go) begin
        status_hit <= status_now;
        angle_hit  <= angle_now;
      end

      if (ctrl.close) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_ANGLE_THRESHOLD: angle_threshold <= cfg.data;
          CFG_FRESHNESS_LIMIT: freshness_limit <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec.valid && rec.ready) begin
      q_op    <= rec.opcode;
      q_id    <= rec.joint_id;
      q_state <= rec.joint_state;
      q_error <= rec.joint_error;
      q_angle <= rec.angle;
      q_last  <= rec.last_in_frame;
    end
    if (ctrl.close) begin
      out_deliver <= ctrl.commit;
      out_reason  <= reason_next;
    end
  end

endmodule

@@ rtl/jfcd_checker.sv @@
// Port-level checks for joint_frame_change_detector_core, attached with a bind.
// Depends on jfcd_pkg for opcode and reason codes.
module jfcd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rec_valid,
  input logic                          rec_ready,
  input logic                          rec_opcode,
  input logic                          rec_last,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          res_deliver,
  input logic [jfcd_pkg::REASON_W-1:0] res_reason
);
  import jfcd_pkg::*;

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_deliver) && $stable(res_reason))
    else $error("stalled result changed or dropped");

  a_deliver_matches_reason: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_deliver == (res_reason != REASON_NONE)) && (res_reason <= REASON_STALE))
    else $error("deliver flag and reason disagree");

  a_result_follows_close: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |->
      $past(rec_valid && rec_ready && (rec_opcode == OP_RECORD) && rec_last, 2))
    else $error("result not two cycles after a frame-closing record");

endmodule

bind joint_frame_change_detector_core jfcd_checker u_jfcd_checker (
  .clk         (clk),
  .rst         (rst),
  .rec_valid   (rec.valid),
  .rec_ready   (rec.ready),
  .rec_opcode  (rec.opcode),
  .rec_last    (rec.last_in_frame),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_deliver (res.deliver),
  .res_reason  (res.reason)
);
